@@ rtl/lrc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lrc_pkg;

  localparam int LABEL_COUNT = 256;
  localparam int COORD_BITS  = 8;

  localparam int LABEL_W   = 8;
  localparam int LBL_AW    = $clog2(LABEL_COUNT);
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W     = 32;
  localparam int COUNT_W   = 25;
  localparam int FRAC_BITS = 8;
  localparam int CENT_W    = 16;
  localparam int BAND_W    = COORD_BITS + 1;
  localparam int SIZE_W    = (COORD_BITS + 1 > CFG_W) ? COORD_BITS + 1 : CFG_W;
  localparam int DIV_STEP_W = $clog2(CENT_W + 1);

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(256);
  localparam logic [SIZE_W-1:0]  SIZE_MAX  = SIZE_W'(1) << COORD_BITS;
  localparam logic [LABEL_W:0]   LBL_LIMIT = (LABEL_W + 1)'(LABEL_COUNT);

  typedef enum logic [1:0] {
    REQ_VOXEL = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS  = 2'd0,
    CFG_ROWS  = 2'd1,
    CFG_BANDS = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_QREAD,
    ST_DSTART,
    ST_DWAIT
  } state_e;

  typedef enum logic [1:0] {
    AX_COL,
    AX_ROW,
    AX_BAND
  } axis_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [LABEL_W-1:0] label;
  } in_item_t;

  typedef struct packed {
    logic               present;
    logic [CENT_W-1:0]  centroid_x;
    logic [CENT_W-1:0]  centroid_y;
    logic [CENT_W-1:0]  centroid_z;
    logic [COUNT_W-1:0] voxel_count;
  } out_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [BAND_W-1:0]     band;
  } coord_t;

  typedef struct packed {
    logic [SUM_W-1:0]   col_sum;
    logic [SUM_W-1:0]   row_sum;
    logic [SUM_W-1:0]   band_sum;
    logic [COUNT_W-1:0] count;
  } entry_t;

  function automatic logic [SIZE_W-1:0] eff_size(logic [CFG_W-1:0] r);
    logic [SIZE_W-1:0] v;
    v = SIZE_W'(r);
    if (r == '0) begin
      return SIZE_W'(1);
    end else if (v > SIZE_MAX) begin
      return SIZE_MAX;
    end
    return v;
  endfunction

  function automatic logic [SUM_W-1:0] sum_add(logic [SUM_W-1:0] a, logic [BAND_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W + 1)'(b);
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] count_inc(logic [COUNT_W-1:0] a);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + (COUNT_W + 1)'(1);
    return s[COUNT_W] ? '1 : s[COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/lrc_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lrc_scan (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [lrc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [lrc_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          advance_i,
  input  wire logic                          clear_i,
  output lrc_pkg::coord_t                    coord_o,
  output logic                               in_frame_o
);

  logic [lrc_pkg::CFG_W-1:0]      cols_q, cols_d;
  logic [lrc_pkg::CFG_W-1:0]      rows_q, rows_d;
  logic [lrc_pkg::CFG_W-1:0]      bands_q, bands_d;
  logic [lrc_pkg::COORD_BITS-1:0] col_q, col_d;
  logic [lrc_pkg::COORD_BITS-1:0] row_q, row_d;
  logic [lrc_pkg::BAND_W-1:0]     band_q, band_d;
  logic [lrc_pkg::SIZE_W-1:0]     col_inc, row_inc;

  always_comb begin
    cols_d  = cols_q;
    rows_d  = rows_q;
    bands_d = bands_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        lrc_pkg::CFG_COLS:  cols_d  = cfg_data_i;
        lrc_pkg::CFG_ROWS:  rows_d  = cfg_data_i;
        lrc_pkg::CFG_BANDS: bands_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    col_inc = lrc_pkg::SIZE_W'(col_q) + lrc_pkg::SIZE_W'(1);
    row_inc = lrc_pkg::SIZE_W'(row_q) + lrc_pkg::SIZE_W'(1);
    col_d   = col_q;
    row_d   = row_q;
    band_d  = band_q;
    if (clear_i) begin
      col_d  = '0;
      row_d  = '0;
      band_d = '0;
    end else if (advance_i) begin
      if (col_inc >= lrc_pkg::eff_size(cols_q)) begin
        col_d = '0;
        if (row_inc >= lrc_pkg::eff_size(rows_q)) begin
          row_d  = '0;
          band_d = band_q + lrc_pkg::BAND_W'(1);
        end else begin
          row_d = row_inc[lrc_pkg::COORD_BITS-1:0];
        end
      end else begin
        col_d = col_inc[lrc_pkg::COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= lrc_pkg::CFG_RESET;
      rows_q  <= lrc_pkg::CFG_RESET;
      bands_q <= lrc_pkg::CFG_RESET;
      col_q   <= '0;
      row_q   <= '0;
      band_q  <= '0;
    end else begin
      cols_q  <= cols_d;
      rows_q  <= rows_d;
      bands_q <= bands_d;
      col_q   <= col_d;
      row_q   <= row_d;
      band_q  <= band_d;
    end
  end

  assign coord_o    = '{col: col_q, row: row_q, band: band_q};
  assign in_frame_o = lrc_pkg::SIZE_W'(band_q) < lrc_pkg::eff_size(bands_q);

endmodule

`default_nettype wire

@@ rtl/lrc_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lrc_table (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       clear_i,
  input  wire logic                       wr_en_i,
  input  wire logic [lrc_pkg::LBL_AW-1:0] wr_label_i,
  input  wire lrc_pkg::coord_t            wr_coord_i,
  input  wire logic                       rd_en_i,
  input  wire logic [lrc_pkg::LBL_AW-1:0] rd_label_i,
  output lrc_pkg::entry_t                 rd_entry_o,
  output logic                            busy_o
);

  lrc_pkg::entry_t                 mem [lrc_pkg::LABEL_COUNT];
  logic [lrc_pkg::LABEL_COUNT-1:0] vld_q, vld_d;

  lrc_pkg::entry_t                 rd_q;
  logic                            rd_vld_q;
  logic [lrc_pkg::LBL_AW-1:0]      rd_addr;
  logic                            rd_any;

  logic                            pend_q, pend_d;
  logic [lrc_pkg::LBL_AW-1:0]      pend_label_q;
  lrc_pkg::coord_t                 pend_coord_q;

  logic                            fwd_vld_q, fwd_vld_d;
  logic [lrc_pkg::LBL_AW-1:0]      fwd_label_q;
  lrc_pkg::entry_t                 fwd_entry_q;

  lrc_pkg::entry_t                 base, upd;

  assign rd_any  = wr_en_i || rd_en_i;
  assign rd_addr = wr_en_i ? wr_label_i : rd_label_i;

  always_comb begin
    if (fwd_vld_q && (fwd_label_q == pend_label_q)) begin
      base = fwd_entry_q;
    end else if (rd_vld_q) begin
      base = rd_q;
    end else begin
      base = '0;
    end
    upd.col_sum  = lrc_pkg::sum_add(base.col_sum, lrc_pkg::BAND_W'(pend_coord_q.col));
    upd.row_sum  = lrc_pkg::sum_add(base.row_sum, lrc_pkg::BAND_W'(pend_coord_q.row));
    upd.band_sum = lrc_pkg::sum_add(base.band_sum, pend_coord_q.band);
    upd.count    = lrc_pkg::count_inc(base.count);
  end

  always_comb begin
    vld_d = vld_q;
    if (clear_i) begin
      vld_d = '0;
    end else if (pend_q) begin
      vld_d[pend_label_q] = 1'b1;
    end
    pend_d    = wr_en_i;
    fwd_vld_d = pend_q && !clear_i;
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      mem[pend_label_q] <= upd;
    end
    if (rd_any) begin
      rd_q     <= mem[rd_addr];
      rd_vld_q <= vld_q[rd_addr];
    end
    if (wr_en_i) begin
      pend_label_q <= wr_label_i;
      pend_coord_q <= wr_coord_i;
    end
    if (pend_q) begin
      fwd_label_q <= pend_label_q;
      fwd_entry_q <= upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      pend_q    <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      vld_q     <= vld_d;
      pend_q    <= pend_d;
      fwd_vld_q <= fwd_vld_d;
    end
  end

  assign rd_entry_o = rd_vld_q ? rd_q : '0;
  assign busy_o     = pend_q;

endmodule

`default_nettype wire

@@ rtl/lrc_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lrc_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [lrc_pkg::SUM_W-1:0]   sum_i,
  input  wire logic [lrc_pkg::COUNT_W-1:0] count_i,
  output logic                             done_o,
  output logic [lrc_pkg::CENT_W-1:0]       quot_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [lrc_pkg::DIV_STEP_W-1:0]     step_q, step_d;
  logic [lrc_pkg::COUNT_W-1:0]        rem_q, rem_d;
  logic [lrc_pkg::COUNT_W-1:0]        div_q, div_d;
  logic [lrc_pkg::CENT_W-1:0]         low_q, low_d;
  logic [lrc_pkg::CENT_W-1:0]         quot_q, quot_d;
  logic [lrc_pkg::COUNT_W:0]          trial;
  logic [lrc_pkg::SUM_W:0]            limit;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    div_d  = div_q;
    low_d  = low_q;
    quot_d = quot_q;
    trial  = {rem_q, low_q[lrc_pkg::CENT_W-1]};
    limit  = (lrc_pkg::SUM_W + 1)'({count_i, lrc_pkg::FRAC_BITS'(0)});
    if (start_i) begin
      div_d = count_i;
      if (count_i == '0) begin
        quot_d = '0;
        done_d = 1'b1;
      end else if ({1'b0, sum_i} >= limit) begin
        quot_d = '1;
        done_d = 1'b1;
      end else begin
        rem_d  = lrc_pkg::COUNT_W'(sum_i[lrc_pkg::SUM_W-1:lrc_pkg::FRAC_BITS]);
        low_d  = {sum_i[lrc_pkg::FRAC_BITS-1:0],
                  (lrc_pkg::CENT_W - lrc_pkg::FRAC_BITS)'(0)};
        quot_d = '0;
        step_d = lrc_pkg::DIV_STEP_W'(lrc_pkg::CENT_W);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d  = lrc_pkg::COUNT_W'(trial - {1'b0, div_q});
        quot_d = {quot_q[lrc_pkg::CENT_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[lrc_pkg::COUNT_W-1:0];
        quot_d = {quot_q[lrc_pkg::CENT_W-2:0], 1'b0};
      end
      low_d  = {low_q[lrc_pkg::CENT_W-2:0], 1'b0};
      step_d = step_q - lrc_pkg::DIV_STEP_W'(1);
      if (step_q == lrc_pkg::DIV_STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    low_q  <= low_d;
    quot_q <= quot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

@@ rtl/label_region_centroid.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Handshake             Payload
// in         input      in_valid_i/in_stall_o  in_data_i (req_type, label)
// out        output     out_valid_o/out_stall_i out_data_o (present, centroids, count)
// cfg        input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Voxels may follow back to back while no query is in progress; the table is
// updated by read-modify-write with a one-entry forward from the last write.
// A query runs one division per axis in the shared serial divider, shorter for an empty label.
// A clear resets the entry valid bits at once, so there is no clearing pass after
// reset. Queries and clears wait while a table write is pending, and a query also waits
// while an earlier result has not been taken.

module label_region_centroid (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire lrc_pkg::in_item_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output lrc_pkg::out_item_t                 out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lrc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [lrc_pkg::CFG_W-1:0]     cfg_data_i
);

  lrc_pkg::state_e            state_q, state_d;
  lrc_pkg::axis_e             axis_q, axis_d;
  lrc_pkg::entry_t            entry_q, entry_d;
  logic                       lbl_ok_q, lbl_ok_d;
  logic [lrc_pkg::CENT_W-1:0] cx_q, cx_d, cy_q, cy_d;
  logic                       out_valid_q, out_valid_d;
  lrc_pkg::out_item_t         out_data_q, out_data_d;

  logic                       in_acc;
  logic                       is_vox, is_query, is_clear;
  logic                       lbl_ok;
  logic                       vox_acc, tbl_wr, query_acc, clear_acc;
  lrc_pkg::coord_t            coord;
  logic                       in_frame;
  lrc_pkg::entry_t            tbl_rd;
  logic                       tbl_busy;
  logic                       div_start, div_done;
  logic [lrc_pkg::CENT_W-1:0] div_quot;
  logic [lrc_pkg::SUM_W-1:0]  div_sum;

  assign is_vox   = in_data_i.req_type == lrc_pkg::REQ_VOXEL;
  assign is_query = in_data_i.req_type == lrc_pkg::REQ_QUERY;
  assign is_clear = in_data_i.req_type == lrc_pkg::REQ_CLEAR;
  assign lbl_ok   = {1'b0, in_data_i.label} < lrc_pkg::LBL_LIMIT;

  assign in_stall_o = (state_q != lrc_pkg::ST_RUN)
                    || (is_query && (tbl_busy || out_valid_q))
                    || (is_clear && tbl_busy);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign vox_acc    = in_acc && is_vox && in_frame;
  assign tbl_wr     = vox_acc && (in_data_i.label != '0) && lbl_ok;
  assign query_acc  = in_acc && is_query;
  assign clear_acc  = in_acc && is_clear;

  assign cfg_ready_o = 1'b1;

  lrc_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (vox_acc),
    .clear_i     (clear_acc),
    .coord_o     (coord),
    .in_frame_o  (in_frame)
  );

  lrc_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (clear_acc),
    .wr_en_i    (tbl_wr),
    .wr_label_i (in_data_i.label[lrc_pkg::LBL_AW-1:0]),
    .wr_coord_i (coord),
    .rd_en_i    (query_acc),
    .rd_label_i (in_data_i.label[lrc_pkg::LBL_AW-1:0]),
    .rd_entry_o (tbl_rd),
    .busy_o     (tbl_busy)
  );

  lrc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (div_sum),
    .count_i (entry_q.count),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    unique case (axis_q)
      lrc_pkg::AX_COL: div_sum = entry_q.col_sum;
      lrc_pkg::AX_ROW: div_sum = entry_q.row_sum;
      default:         div_sum = entry_q.band_sum;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    entry_d     = entry_q;
    lbl_ok_d    = lbl_ok_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    div_start   = 1'b0;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      lrc_pkg::ST_RUN: begin
        if (query_acc) begin
          lbl_ok_d = lbl_ok;
          state_d  = lrc_pkg::ST_QREAD;
        end
      end
      lrc_pkg::ST_QREAD: begin
        entry_d = lbl_ok_q ? tbl_rd : '0;
        axis_d  = lrc_pkg::AX_COL;
        state_d = lrc_pkg::ST_DSTART;
      end
      lrc_pkg::ST_DSTART: begin
        div_start = 1'b1;
        state_d   = lrc_pkg::ST_DWAIT;
      end
      lrc_pkg::ST_DWAIT: begin
        if (div_done) begin
          unique case (axis_q)
            lrc_pkg::AX_COL: begin
              cx_d    = div_quot;
              axis_d  = lrc_pkg::AX_ROW;
              state_d = lrc_pkg::ST_DSTART;
            end
            lrc_pkg::AX_ROW: begin
              cy_d    = div_quot;
              axis_d  = lrc_pkg::AX_BAND;
              state_d = lrc_pkg::ST_DSTART;
            end
            default: begin
              out_data_d.present     = entry_q.count != '0;
              out_data_d.centroid_x  = cx_q;
              out_data_d.centroid_y  = cy_q;
              out_data_d.centroid_z  = div_quot;
              out_data_d.voxel_count = entry_q.count;
              out_valid_d            = 1'b1;
              state_d                = lrc_pkg::ST_RUN;
            end
          endcase
        end
      end
      default: state_d = lrc_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q    <= entry_d;
    lbl_ok_q   <= lbl_ok_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lrc_pkg::ST_RUN;
      axis_q      <= lrc_pkg::AX_COL;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_result_from_divider: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == lrc_pkg::ST_DWAIT && div_done))
    else $error("result appeared without a finished division");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == lrc_pkg::ST_DWAIT)
    else $error("divider finished outside the wait state");

  a_no_write_during_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != lrc_pkg::ST_RUN) |-> !tbl_busy)
    else $error("table write pending while a query is in progress");

  a_present_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.present == (out_data_o.voxel_count != '0)))
    else $error("present flag disagrees with voxel count");
`endif

endmodule

`default_nettype wire

@@ dv/label_region_centroid_tb.sv @@
`timescale 1ns / 1ps

module label_region_centroid_tb;
  import lrc_pkg::*;

  localparam logic [1:0]           REQ_RESERVED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;
  localparam int unsigned IDLE_PCT      = 22;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned ITEM_TARGET   = 950;
  localparam int unsigned PRINT_LIMIT   = 100;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;

  in_item_t    item_queue[$];
  out_item_t   expected_stats[$];
  int unsigned items_made;
  int unsigned err_count;
  bit          in_taken;
  bit          no_idle;
  bit          hold_arm;
  int unsigned hold_left;

  bit [SUM_W-1:0]   col_sum  [LABEL_COUNT];
  bit [SUM_W-1:0]   row_sum  [LABEL_COUNT];
  bit [SUM_W-1:0]   band_sum [LABEL_COUNT];
  bit [COUNT_W-1:0] vox_cnt  [LABEL_COUNT];
  bit [8:0]         col_pos;
  bit [8:0]         row_pos;
  bit [8:0]         band_pos;
  logic [CFG_W-1:0] cols_cfg  = CFG_RESET;
  logic [CFG_W-1:0] rows_cfg  = CFG_RESET;
  logic [CFG_W-1:0] bands_cfg = CFG_RESET;

  label_region_centroid u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int unsigned size_used(logic [CFG_W-1:0] r);
    if (r == '0) begin
      return 1;
    end
    if (r > (1 << COORD_BITS)) begin
      return 1 << COORD_BITS;
    end
    return r;
  endfunction

  function automatic bit [SUM_W-1:0] sum_sat(bit [SUM_W-1:0] a, bit [8:0] b);
    bit [SUM_W:0] s;
    s = {1'b0, a} + b;
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  function automatic logic [CENT_W-1:0] mean_8p8(bit [SUM_W-1:0] sum, bit [COUNT_W-1:0] cnt);
    bit [SUM_W+FRAC_BITS-1:0] q;
    if (cnt == '0) begin
      return '0;
    end
    q = {sum, 8'h00} / cnt;
    return (q > 16'hFFFF) ? 16'hFFFF : q[CENT_W-1:0];
  endfunction

  function automatic void label_stats_step(in_item_t it);
    out_item_t   ans;
    int unsigned lb;
    lb = it.label;
    case (it.req_type)
      REQ_VOXEL: begin
        if (band_pos < size_used(bands_cfg)) begin
          if (lb != 0 && lb < LABEL_COUNT) begin
            col_sum[lb]  = sum_sat(col_sum[lb], col_pos);
            row_sum[lb]  = sum_sat(row_sum[lb], row_pos);
            band_sum[lb] = sum_sat(band_sum[lb], band_pos);
            if (vox_cnt[lb] != '1) begin
              vox_cnt[lb] = vox_cnt[lb] + 1'b1;
            end
          end
          col_pos = col_pos + 1'b1;
          if (col_pos >= size_used(cols_cfg)) begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
            if (row_pos >= size_used(rows_cfg)) begin
              row_pos  = '0;
              band_pos = band_pos + 1'b1;
            end
          end
        end
      end
      REQ_QUERY: begin
        ans = '0;
        if (lb < LABEL_COUNT) begin
          ans.present     = vox_cnt[lb] != '0;
          ans.centroid_x  = mean_8p8(col_sum[lb], vox_cnt[lb]);
          ans.centroid_y  = mean_8p8(row_sum[lb], vox_cnt[lb]);
          ans.centroid_z  = mean_8p8(band_sum[lb], vox_cnt[lb]);
          ans.voxel_count = vox_cnt[lb];
        end
        expected_stats.push_back(ans);
      end
      REQ_CLEAR: begin
        for (int k = 0; k < LABEL_COUNT; k++) begin
          col_sum[k]  = '0;
          row_sum[k]  = '0;
          band_sum[k] = '0;
          vox_cnt[k]  = '0;
        end
        col_pos  = '0;
        row_pos  = '0;
        band_pos = '0;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_LIMIT) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  always @(posedge clk_i) begin : monitor
    out_item_t want;
    if (!rst_ni) begin
      in_taken = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_stats.size() == 0) begin
          report_mismatch($sformatf("result transfer with no query pending: %h", out_data_o));
        end else begin
          want = expected_stats.pop_front();
          check_field("present", out_data_o.present, want.present);
          check_field("centroid_x", out_data_o.centroid_x, want.centroid_x);
          check_field("centroid_y", out_data_o.centroid_y, want.centroid_y);
          check_field("centroid_z", out_data_o.centroid_z, want.centroid_z);
          check_field("voxel_count", out_data_o.voxel_count, want.voxel_count);
        end
      end
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) begin
        label_stats_step(in_data_i);
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (item_queue.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
        in_data_i  <= item_queue.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_arm) begin
      hold_arm = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic push_item(input logic [1:0] kind, input logic [LABEL_W-1:0] lbl);
    in_item_t it;
    it.req_type = kind;
    it.label    = lbl;
    item_queue.push_back(it);
    items_made++;
  endtask

  task automatic settle();
    while (item_queue.size() != 0 || in_valid_i || expected_stats.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_COLS:  cols_cfg  = val;
      CFG_ROWS:  rows_cfg  = val;
      CFG_BANDS: bands_cfg = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_sizes(input logic [CFG_W-1:0] c, input logic [CFG_W-1:0] r,
                           input logic [CFG_W-1:0] b);
    settle();
    write_size(CFG_COLS, c);
    write_size(CFG_ROWS, r);
    write_size(CFG_BANDS, b);
  endtask

  function automatic logic [CFG_W-1:0] rand_size();
    case ($urandom_range(9))
      0: return '0;
      1: return CFG_W'(1);
      2: return CFG_W'($urandom_range(256, 511));
      default: return CFG_W'($urandom_range(2, 8));
    endcase
  endfunction

  // Voxels mostly use a few labels so that the sums build up; queries mostly ask
  // for those labels.
  task automatic scan_phase(input int unsigned voxels, input int unsigned query_pct,
                            input bit restart);
    logic [LABEL_W-1:0] pool[4];
    logic [LABEL_W-1:0] lbl;
    int unsigned        made;
    int unsigned        roll;
    int unsigned        pick;
    for (int k = 0; k < 4; k++) begin
      pool[k] = LABEL_W'($urandom_range(1, 255));
    end
    if ($urandom_range(3) == 0) begin
      pool[0] = 8'hFF;
    end
    if (restart) begin
      push_item(REQ_CLEAR, LABEL_W'($urandom));
    end
    made = 0;
    while (made < voxels) begin
      roll = $urandom_range(99);
      pick = $urandom_range(3);
      if (roll < query_pct) begin
        push_item(REQ_QUERY, ($urandom_range(4) != 0) ? pool[pick] : LABEL_W'($urandom));
      end else if (roll < query_pct + 2) begin
        push_item(REQ_RESERVED, LABEL_W'($urandom));
      end else begin
        case ($urandom_range(9))
          0: lbl = '0;
          1: lbl = LABEL_W'($urandom);
          default: lbl = pool[pick];
        endcase
        push_item(REQ_VOXEL, lbl);
        made++;
      end
    end
    for (int k = 0; k < 4; k++) begin
      push_item(REQ_QUERY, pool[k]);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    push_item(REQ_VOXEL, 8'd255);
    push_item(REQ_VOXEL, 8'd1);
    push_item(REQ_VOXEL, 8'd0);
    push_item(REQ_VOXEL, 8'hAA);
    push_item(REQ_VOXEL, 8'h55);
    push_item(REQ_VOXEL, 8'd255);
    push_item(REQ_RESERVED, 8'd255);
    push_item(REQ_QUERY, 8'd255);
    push_item(REQ_QUERY, 8'd1);
    push_item(REQ_QUERY, 8'd0);
    push_item(REQ_QUERY, 8'hAA);
    push_item(REQ_QUERY, 8'h55);
    push_item(REQ_QUERY, 8'd200);
    push_item(REQ_CLEAR, 8'd0);
    push_item(REQ_QUERY, 8'd255);
    push_item(REQ_VOXEL, 8'd1);
    push_item(REQ_QUERY, 8'd1);
    settle();

    write_size(CFG_SPARE, CFG_W'($urandom_range(0, 511)));
    set_sizes(CFG_W'(1), CFG_W'(1), CFG_W'(1));
    scan_phase(6, 30, 1'b1);
    set_sizes('0, '0, '0);
    scan_phase(6, 30, 1'b1);

    // One voxel per band, so the band position walks up to the top of its range.
    set_sizes(CFG_W'(1), CFG_W'(1), CFG_W'(300));
    scan_phase(262, 15, 1'b1);

    // Shrinking the row length mid-scan leaves the column position past the new size.
    set_sizes(CFG_W'(511), CFG_W'(2), CFG_W'(1));
    scan_phase(40, 20, 1'b1);
    set_sizes(CFG_W'(8), CFG_W'(3), CFG_W'(2));
    scan_phase(30, 20, 1'b0);

    set_sizes(CFG_W'(4), CFG_W'(4), CFG_W'(4));
    hold_arm = 1'b1;
    scan_phase(60, 45, 1'b1);
    settle();

    no_idle = 1'b1;
    scan_phase(80, 25, 1'b1);
    settle();
    no_idle = 1'b0;

    while (items_made < ITEM_TARGET) begin
      set_sizes(rand_size(), rand_size(), rand_size());
      scan_phase($urandom_range(8, 48), 20, $urandom_range(3) != 0);
    end
    settle();

    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
